// ===== hdl/blr_pkg.sv =====
// Shared types and codes of the line rasterizer.
// No dependencies; the top level, blr_core and the bench import this package.
package blr_pkg;

	// Command codes carried by an input beat.
	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// Walk flags kept between beats.
	typedef struct packed {
		logic active;     // a line is being walked
		logic swapped;    // major axis is y
		logic step_down;  // minor coordinate falls along the walk
	} blr_flags_t;

endpackage

// ===== hdl/blr_cmd_if.sv =====
// Command channel of the line rasterizer: valid/ready plus endpoints and color.
// Depends on nothing; COORD_BITS sets the coordinate width.
interface blr_cmd_if #(
	parameter int COORD_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic [15:0]           line_color;

	modport source (
		output valid, command, start_x, start_y, end_x, end_y, line_color,
		input  ready
	);
	modport sink (
		input  valid, command, start_x, start_y, end_x, end_y, line_color,
		output ready
	);
endinterface

// ===== hdl/blr_pix_if.sv =====
// Pixel channel of the line rasterizer: valid/ready plus one pixel.
// Depends on nothing; COORD_BITS sets the coordinate width.
interface blr_pix_if #(
	parameter int COORD_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [15:0]           pixel_color;
	logic                  last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready
	);
endinterface

// ===== hdl/bresenham_line_rasterizer.sv =====
// Top level of the Bresenham line rasterizer.
// Depends on blr_pkg, blr_cmd_if, blr_pix_if and blr_core.
//
// A start beat on cmd (command = CMD_START) sets up a line between two
// endpoints and returns its first pixel; each step beat (command = CMD_STEP)
// returns the next pixel, and the pixel on the far endpoint carries
// last_pixel = 1 and ends the line. The major axis is the one with the larger
// span (x on a tie); pixels come out with the major coordinate rising, so a
// line may be walked from either of its given endpoints. A step beat with no
// line in progress is taken and dropped without a pixel; a start beat while a
// line is in progress abandons the old line. The block takes one beat per
// clock and returns one pixel per clock; a pixel passes through the input
// register and then the result register after its command beat. The walk
// update, an add, a compare and a subtract on the error term, is
// combinational and sets that rate. Backpressure on pix stalls the input
// only when both the input register and the result register are full.
module bresenham_line_rasterizer import blr_pkg::*; #(
	parameter int COORD_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	blr_cmd_if.sink      cmd,
	blr_pix_if.source    pix
);
	localparam int ErrBits = COORD_BITS + 3;

	// Input register
	logic                  valid_s1;
	logic                  step_s1;
	logic [COORD_BITS-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic [15:0]           color_s1;

	// Walk state
	blr_flags_t                flags_q;
	logic [COORD_BITS-1:0]     major_pos_q, major_end_q, minor_pos_q;
	logic [COORD_BITS-1:0]     major_delta_q, minor_mag_q;
	logic signed [ErrBits-1:0] err_q;
	logic [15:0]               color_q;

	// Result register
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [15:0]           out_color_q;
	logic                  out_last_q;

	// Core outputs
	blr_flags_t                flags_n;
	logic [COORD_BITS-1:0]     major_pos_n, major_end_n, minor_pos_n;
	logic [COORD_BITS-1:0]     major_delta_n, minor_mag_n;
	logic signed [ErrBits-1:0] err_n;
	logic                      res_valid, res_last;
	logic [COORD_BITS-1:0]     res_x, res_y;
	logic [15:0]               res_color;

	logic accept, advance;

	// Advance the held beat whenever the result register is free or drains
	assign advance   = valid_s1 && (!out_valid_q || pix.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1  <= cmd.command == CMD_STEP;
			x0_s1    <= cmd.start_x;
			y0_s1    <= cmd.start_y;
			x1_s1    <= cmd.end_x;
			y1_s1    <= cmd.end_y;
			color_s1 <= cmd.line_color;
		end
	end

	blr_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.is_step       (step_s1),
		.x0            (x0_s1),
		.y0            (y0_s1),
		.x1            (x1_s1),
		.y1            (y1_s1),
		.flags         (flags_q),
		.major_pos     (major_pos_q),
		.major_end     (major_end_q),
		.minor_pos     (minor_pos_q),
		.major_delta   (major_delta_q),
		.minor_mag     (minor_mag_q),
		.err           (err_q),
		.flags_n       (flags_n),
		.major_pos_n   (major_pos_n),
		.major_end_n   (major_end_n),
		.minor_pos_n   (minor_pos_n),
		.major_delta_n (major_delta_n),
		.minor_mag_n   (minor_mag_n),
		.err_n         (err_n),
		.res_valid     (res_valid),
		.res_x         (res_x),
		.res_y         (res_y),
		.res_last      (res_last)
	);

	// A start beat latches the new color and shows it on its first pixel
	assign res_color = step_s1 ? color_q : color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '0;
			major_pos_q   <= '0;
			major_end_q   <= '0;
			minor_pos_q   <= '0;
			major_delta_q <= '0;
			minor_mag_q   <= '0;
			err_q         <= '0;
			color_q       <= '0;
		end else if (advance) begin
			flags_q       <= flags_n;
			major_pos_q   <= major_pos_n;
			major_end_q   <= major_end_n;
			minor_pos_q   <= minor_pos_n;
			major_delta_q <= major_delta_n;
			minor_mag_q   <= minor_mag_n;
			err_q         <= err_n;
			color_q       <= res_color;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_x_q     <= res_x;
			out_y_q     <= res_y;
			out_color_q <= res_color;
			out_last_q  <= res_last;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = out_x_q;
	assign pix.pixel_y     = out_y_q;
	assign pix.pixel_color = out_color_q;
	assign pix.last_pixel  = out_last_q;

	// The error term stays within one major delta of zero during a walk
	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.active |-> (err_q <= $signed({3'b000, major_delta_q}))
			&& (err_q >= -$signed({3'b000, major_delta_q})))
		else $error("error term out of range");

	// The last pixel of a line ends the walk
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_last |=> !flags_q.active)
		else $error("walk still active after last pixel");

	// A step with no line in progress yields no pixel
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_s1 && !flags_q.active |-> !res_valid)
		else $error("pixel from a step with no line");

	// Input stalls only when both registers are full and pix is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && out_valid_q && !pix.ready)
		else $error("input stalled without cause");

endmodule

// ===== hdl/blr_core.sv =====
// Combinational walk update of the line rasterizer: line setup on start,
// one Bresenham step on step, and the pixel that follows. Uses blr_pkg.
module blr_core import blr_pkg::*; #(
	parameter int COORD_BITS = 8
) (
	input  logic                         is_step,
	input  logic [COORD_BITS-1:0]        x0,
	input  logic [COORD_BITS-1:0]        y0,
	input  logic [COORD_BITS-1:0]        x1,
	input  logic [COORD_BITS-1:0]        y1,
	input  blr_flags_t                   flags,
	input  logic [COORD_BITS-1:0]        major_pos,
	input  logic [COORD_BITS-1:0]        major_end,
	input  logic [COORD_BITS-1:0]        minor_pos,
	input  logic [COORD_BITS-1:0]        major_delta,
	input  logic [COORD_BITS-1:0]        minor_mag,
	input  logic signed [COORD_BITS+2:0] err,
	output blr_flags_t                   flags_n,
	output logic [COORD_BITS-1:0]        major_pos_n,
	output logic [COORD_BITS-1:0]        major_end_n,
	output logic [COORD_BITS-1:0]        minor_pos_n,
	output logic [COORD_BITS-1:0]        major_delta_n,
	output logic [COORD_BITS-1:0]        minor_mag_n,
	output logic signed [COORD_BITS+2:0] err_n,
	output logic                         res_valid,
	output logic [COORD_BITS-1:0]        res_x,
	output logic [COORD_BITS-1:0]        res_y,
	output logic                         res_last
);
	localparam int ErrBits = COORD_BITS + 3;
	localparam logic [COORD_BITS-1:0] One = COORD_BITS'(1);

	logic [COORD_BITS-1:0] adx, ady, a0, b0, a1, b1;
	logic [COORD_BITS-1:0] st_major, st_end, st_minor, st_minor_end;
	logic                  st_swap, st_rev, st_down;
	logic signed [ErrBits-1:0] err_sum, major_ext;
	logic                  minor_move;

	// Line setup
	always_comb begin
		adx          = (x1 >= x0) ? x1 - x0 : x0 - x1;
		ady          = (y1 >= y0) ? y1 - y0 : y0 - y1;
		st_swap      = adx < ady;
		a0           = st_swap ? y0 : x0;
		b0           = st_swap ? x0 : y0;
		a1           = st_swap ? y1 : x1;
		b1           = st_swap ? x1 : y1;
		st_rev       = a1 < a0;
		st_major     = st_rev ? a1 : a0;
		st_end       = st_rev ? a0 : a1;
		st_minor     = st_rev ? b1 : b0;
		st_minor_end = st_rev ? b0 : b1;
		st_down      = st_minor_end < st_minor;
	end

	// Step: error grows by twice the minor delta
	always_comb begin
		err_sum    = err + $signed({2'b00, minor_mag, 1'b0});
		major_ext  = $signed({3'b000, major_delta});
		minor_move = err_sum > major_ext;
	end

	always_comb begin
		flags_n       = flags;
		major_pos_n   = major_pos;
		major_end_n   = major_end;
		minor_pos_n   = minor_pos;
		major_delta_n = major_delta;
		minor_mag_n   = minor_mag;
		err_n         = err;
		res_valid     = 1'b0;
		if (!is_step) begin
			flags_n.swapped   = st_swap;
			flags_n.step_down = st_down;
			major_pos_n       = st_major;
			major_end_n       = st_end;
			minor_pos_n       = st_minor;
			major_delta_n     = st_end - st_major;
			minor_mag_n       = st_down ? st_minor - st_minor_end : st_minor_end - st_minor;
			err_n             = '0;
			res_valid         = 1'b1;
		end else if (flags.active) begin
			major_pos_n = major_pos + One;
			if (minor_move) begin
				minor_pos_n = flags.step_down ? minor_pos - One : minor_pos + One;
				err_n       = err_sum - $signed({2'b00, major_delta, 1'b0});
			end else begin
				err_n = err_sum;
			end
			res_valid = 1'b1;
		end
		// Pixel from the updated walk; the last one ends the line
		res_last      = major_pos_n == major_end_n;
		res_x         = flags_n.swapped ? minor_pos_n : major_pos_n;
		res_y         = flags_n.swapped ? major_pos_n : minor_pos_n;
		if (res_valid) begin
			flags_n.active = !res_last;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for bresenham_line_rasterizer: directed table, then random lines.
// Depends on blr_pkg, blr_cmd_if, blr_pix_if and the rasterizer top level.
// Every command beat is fed to a walk predictor; every pixel beat is checked against it or a pinned row.
module tb import blr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS   = 8;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;
	localparam int IDLE_PERCENT = 7;
	localparam int TIMEOUT_NS   = 2_000_000;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  sx;
		logic [7:0]  sy;
		logic [7:0]  ex;
		logic [7:0]  ey;
		logic [15:0] color;
	} cmd_beat_t;

	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] color;
		logic        last;
	} pixel_t;

	// One stimulus row. A pinned row carries a hand-written expectation that
	// overrides the predictor's output for that beat.
	typedef struct packed {
		cmd_beat_t beat;
		logic      pinned;
		logic      emits;
		pixel_t    pix;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	blr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
	blr_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

	bresenham_line_rasterizer #(.COORD_BITS(COORD_BITS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.pix    (pix_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Walk state of the predictor, mirroring what the block keeps between beats.
	logic               walk_active      = 1'b0;
	logic               walk_swapped     = 1'b0;
	logic [7:0]         walk_major       = '0;
	logic [7:0]         walk_major_end   = '0;
	logic [7:0]         walk_minor       = '0;
	logic [7:0]         walk_major_span  = '0;
	logic [7:0]         walk_minor_span  = '0;
	logic               walk_down        = 1'b0;
	logic signed [10:0] walk_err         = '0;
	logic [15:0]        walk_color       = '0;

	pixel_t    pixel_q[$];   // pixels still owed by the block, oldest first
	stim_row_t pinned_q[$];  // rows driven but not yet taken, oldest first

	int  error_count    = 0;
	int  beats_taken    = 0;
	int  pixels_checked = 0;
	int  lines_started  = 0;
	int  line_ends      = 0;
	bit  idle_enabled   = 1'b1;

	// Advance the predicted walk by one command beat. Return 1 when the beat
	// yields a pixel, with that pixel in p.
	function automatic bit rasterize_beat(input cmd_beat_t b, output pixel_t p);
		logic [7:0] adx, ady, a0, b0, a1, b1;
		int         e;
		p = '0;
		if (b.command == CMD_START) begin
			adx = (b.ex >= b.sx) ? b.ex - b.sx : b.sx - b.ex;
			ady = (b.ey >= b.sy) ? b.ey - b.sy : b.sy - b.ey;
			// Take y as the major axis only when strictly steeper; a tie stays on x.
			walk_swapped = adx < ady;
			if (walk_swapped) begin
				{a0, b0, a1, b1} = {b.sy, b.sx, b.ey, b.ex};
			end else begin
				{a0, b0, a1, b1} = {b.sx, b.sy, b.ex, b.ey};
			end
			// Order the endpoints so the major coordinate rises along the walk.
			if (a1 < a0) begin
				{a0, a1} = {a1, a0};
				{b0, b1} = {b1, b0};
			end
			walk_major      = a0;
			walk_major_end  = a1;
			walk_minor      = b0;
			walk_major_span = a1 - a0;
			walk_down       = b1 < b0;
			walk_minor_span = walk_down ? b0 - b1 : b1 - b0;
			walk_err        = '0;
			walk_color      = b.color;
			walk_active     = 1'b1;
			lines_started++;
		end else begin
			// A step with no line in progress is swallowed without a pixel.
			if (!walk_active)
				return 1'b0;
			e = int'(walk_err) + 2 * int'(walk_minor_span);
			if (e > int'(walk_major_span)) begin
				walk_minor = walk_down ? walk_minor - 8'd1 : walk_minor + 8'd1;
				e -= 2 * int'(walk_major_span);
			end
			walk_err   = 11'(e);
			walk_major = walk_major + 8'd1;
		end
		p.x     = walk_swapped ? walk_minor : walk_major;
		p.y     = walk_swapped ? walk_major : walk_minor;
		p.color = walk_color;
		p.last  = walk_major == walk_major_end;
		// The far endpoint closes the line.
		if (p.last)
			walk_active = 1'b0;
		return 1'b1;
	endfunction

	function automatic void note_mismatch(input string what, input pixel_t want,
	                                      input pixel_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch @%0t: %s: want x=%0d y=%0d c=%h l=%0b, got x=%0d y=%0d c=%h l=%0b",
				$realtime, what, want.x, want.y, want.color, want.last,
				got.x, got.y, got.color, got.last);
	endfunction

	function automatic stim_row_t open_row(input cmd_t c, input logic [7:0] sx,
	                                       input logic [7:0] sy, input logic [7:0] ex,
	                                       input logic [7:0] ey, input logic [15:0] color);
		stim_row_t r;
		r      = '0;
		r.beat = '{c, sx, sy, ex, ey, color};
		return r;
	endfunction

	function automatic stim_row_t fixed_row(input cmd_t c, input logic [7:0] sx,
	                                        input logic [7:0] sy, input logic [7:0] ex,
	                                        input logic [7:0] ey, input logic [15:0] color,
	                                        input logic emits, input logic [7:0] px,
	                                        input logic [7:0] py, input logic [15:0] pc,
	                                        input logic pl);
		stim_row_t r;
		r        = open_row(c, sx, sy, ex, ey, color);
		r.pinned = 1'b1;
		r.emits  = emits;
		r.pix    = '{px, py, pc, pl};
		return r;
	endfunction

	// Fill every payload field at random; step beats carry them as don't-care.
	function automatic stim_row_t scrambled_row(input cmd_t c);
		return open_row(c, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(65535)));
	endfunction

	// Pick a coordinate within a short reach of c, clamped to the screen.
	function automatic logic [7:0] near(input logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(30)) - 15;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// Present one command beat and hold it until the block takes it. Insert a
	// random run of idle cycles first while idling is enabled.
	task automatic send_beat(input stim_row_t r);
		int gap;
		gap = 0;
		while (idle_enabled && $urandom_range(99) < IDLE_PERCENT)
			gap++;
		pinned_q.push_back(r);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid      <= 1'b1;
		cmd_bus.command    <= r.beat.command;
		cmd_bus.start_x    <= r.beat.sx;
		cmd_bus.start_y    <= r.beat.sy;
		cmd_bus.end_x      <= r.beat.ex;
		cmd_bus.end_y      <= r.beat.ey;
		cmd_bus.line_color <= r.beat.color;
		do @(posedge clk); while (!cmd_bus.ready);
	endtask

	// Drop valid and hold off until every owed pixel has come back. The first
	// edge lets the monitor book the beat taken at the current edge.
	task automatic drain_pixels();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (pixel_q.size() != 0);
	endtask

	// Monitor: book taken command beats into the predictor, then check pixel
	// beats against the oldest owed pixel. All block outputs change in the NBA
	// region, so values read here are the ones the edge acted on.
	always @(posedge clk) begin : monitor
		stim_row_t r;
		cmd_beat_t b;
		pixel_t    p, got;
		bit        emits;
		if (arst_n) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				r = pinned_q.pop_front();
				b = '{cmd_t'(cmd_bus.command), cmd_bus.start_x, cmd_bus.start_y,
					cmd_bus.end_x, cmd_bus.end_y, cmd_bus.line_color};
				emits = rasterize_beat(b, p);
				if (r.pinned) begin
					emits = r.emits;
					p     = r.pix;
				end
				if (emits)
					pixel_q.push_back(p);
				beats_taken++;
			end
			if (pix_bus.valid && pix_bus.ready) begin
				got = '{pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color,
					pix_bus.last_pixel};
				if (pixel_q.size() == 0) begin
					note_mismatch("pixel with none owed", '0, got);
				end else begin
					p = pixel_q.pop_front();
					if (got.x !== p.x || got.y !== p.y || got.color !== p.color ||
					    got.last !== p.last)
						note_mismatch("pixel", p, got);
					pixels_checked++;
					if (got.last === 1'b1)
						line_ends++;
				end
			end
		end
	end

	// Pixel sink: stall at random while idling is enabled.
	initial begin
		pix_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			pix_bus.ready <= !(idle_enabled && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: timeout with %0d pixels still owed", pixel_q.size());
		$display("tb: errors");
		$finish;
	end

	initial begin : stimulus
		stim_row_t directed_rows[$];
		stim_row_t r;
		int        sent, next_drain, kind, span, n, i, dx, dy;
		cmd_beat_t b;

		cmd_bus.valid      <= 1'b0;
		cmd_bus.command    <= CMD_START;
		cmd_bus.start_x    <= '0;
		cmd_bus.start_y    <= '0;
		cmd_bus.end_x      <= '0;
		cmd_bus.end_y      <= '0;
		cmd_bus.line_color <= '0;

		// Directed table. Pinned rows state the pixel outright; open rows go
		// through the predictor.
		// Step with no line after reset: swallowed.
		directed_rows.push_back(fixed_row(CMD_STEP, 255, 255, 255, 255, 16'hFFFF,
			1'b0, 0, 0, 16'h0000, 1'b0));
		// Single-point lines at both corners: first pixel is also the last.
		directed_rows.push_back(fixed_row(CMD_START, 0, 0, 0, 0, 16'h0000,
			1'b1, 0, 0, 16'h0000, 1'b1));
		directed_rows.push_back(fixed_row(CMD_STEP, 0, 0, 0, 0, 16'h0000,
			1'b0, 0, 0, 16'h0000, 1'b0));
		directed_rows.push_back(fixed_row(CMD_START, 255, 255, 255, 255, 16'hFFFF,
			1'b1, 255, 255, 16'hFFFF, 1'b1));
		// Short horizontal line walked to its end, then one step too many.
		directed_rows.push_back(fixed_row(CMD_START, 0, 10, 3, 10, 16'h1234,
			1'b1, 0, 10, 16'h1234, 1'b0));
		directed_rows.push_back(fixed_row(CMD_STEP, 0, 0, 0, 0, 16'h0000,
			1'b1, 1, 10, 16'h1234, 1'b0));
		directed_rows.push_back(fixed_row(CMD_STEP, 0, 0, 0, 0, 16'h0000,
			1'b1, 2, 10, 16'h1234, 1'b0));
		directed_rows.push_back(fixed_row(CMD_STEP, 0, 0, 0, 0, 16'h0000,
			1'b1, 3, 10, 16'h1234, 1'b1));
		directed_rows.push_back(fixed_row(CMD_STEP, 0, 0, 0, 0, 16'h0000,
			1'b0, 0, 0, 16'h0000, 1'b0));
		// Same line given right to left: the walk still starts at the low x.
		directed_rows.push_back(fixed_row(CMD_START, 3, 10, 0, 10, 16'h4321,
			1'b1, 0, 10, 16'h4321, 1'b0));
		directed_rows.push_back(open_row(CMD_STEP, 0, 0, 0, 0, 16'h0000));
		// Full diagonal: tie keeps x major; abandoned after two steps by an
		// anti-diagonal whose minor coordinate falls.
		directed_rows.push_back(open_row(CMD_START, 0, 0, 255, 255, 16'hAAAA));
		directed_rows.push_back(open_row(CMD_STEP, 0, 0, 0, 0, 16'h0000));
		directed_rows.push_back(open_row(CMD_STEP, 0, 0, 0, 0, 16'h0000));
		directed_rows.push_back(open_row(CMD_START, 255, 0, 0, 255, 16'h5555));
		directed_rows.push_back(open_row(CMD_STEP, 0, 0, 0, 0, 16'h0000));
		directed_rows.push_back(open_row(CMD_STEP, 0, 0, 0, 0, 16'h0000));
		// Steep line walked to its end plus one swallowed step.
		directed_rows.push_back(open_row(CMD_START, 10, 0, 12, 5, 16'h0F0F));
		for (i = 0; i < 6; i++)
			directed_rows.push_back(open_row(CMD_STEP, 255, 255, 255, 255, 16'hFFFF));
		// Steep line given top to bottom with x falling.
		directed_rows.push_back(open_row(CMD_START, 200, 255, 255, 0, 16'hF81F));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_beat(directed_rows[k]);
		drain_pixels();

		// Random part: mostly whole lines with random content, some cut short
		// by a new start, some overrun with swallowed steps, and some noise.
		sent       = 0;
		next_drain = 200;
		while (sent < RANDOM_ITEMS) begin
			// Hold a long quiet window with no idling on either side.
			idle_enabled = !(sent >= 500 && sent < 750);
			if (sent >= next_drain) begin
				drain_pixels();
				next_drain += 200 + $urandom_range(100);
			end
			kind = $urandom_range(99);
			if (kind < 10) begin
				r = scrambled_row(cmd_t'($urandom_range(1)));
				send_beat(r);
				if (r.beat.command == CMD_START)
					sent++;
			end else begin
				r = scrambled_row(CMD_START);
				// Keep most lines short; the rest have endpoints anywhere on the screen.
				if ($urandom_range(99) < 85) begin
					r.beat.ex = near(r.beat.sx);
					r.beat.ey = near(r.beat.sy);
				end
				b    = r.beat;
				dx   = (b.ex >= b.sx) ? int'(b.ex - b.sx) : int'(b.sx - b.ex);
				dy   = (b.ey >= b.sy) ? int'(b.ey - b.sy) : int'(b.sy - b.ey);
				span = (dx > dy) ? dx : dy;
				kind = $urandom_range(99);
				if (kind < 70)
					n = span;
				else if (kind < 85)
					n = (span > 0) ? int'($urandom_range(span - 1)) : 0;
				else
					n = span + int'($urandom_range(3, 1));
				send_beat(r);
				sent++;
				for (i = 0; i < n; i++) begin
					send_beat(scrambled_row(CMD_STEP));
					if (i < span)
						sent++;
				end
			end
		end

		idle_enabled = 1'b1;
		drain_pixels();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pixel_q.size() != 0) begin
			error_count++;
			$display("mismatch: %0d owed pixels never arrived", pixel_q.size());
		end
		$display("tb: %0d command beats taken, %0d lines started, %0d ran to their end",
			beats_taken, lines_started, line_ends);
		$display("tb: %0d pixels compared, %0d mismatches", pixels_checked, error_count);
		if (error_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/blr_pkg.sv
hdl/blr_cmd_if.sv
hdl/blr_pix_if.sv
hdl/blr_core.sv
hdl/bresenham_line_rasterizer.sv
tb/tb.sv
